// ----- design/cbcb_pkg.sv -----
`default_nettype none

package cbcb_pkg;

    // Width of the column and row counters inside the block.
    localparam int COORD_BITS = 12;
    // Fixed widths of the result fields and registers.
    localparam int BOX_BITS   = 12;
    localparam int COUNT_BITS = 25;
    localparam int LEVEL_BITS = 8;
    localparam int SIZE_BITS  = 13;
    localparam int CFG_DATA_BITS  = 25;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DARK_LEVEL    = 3'd0,
        CFG_BRIGHT_LEVEL  = 3'd1,
        CFG_CHROMA_MARGIN = 3'd2,
        CFG_FRAME_WIDTH   = 3'd3,
        CFG_FRAME_HEIGHT  = 3'd4,
        CFG_MIN_COUNT     = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] dark_level;
        logic [LEVEL_BITS-1:0] bright_level;
        logic [LEVEL_BITS-1:0] chroma_margin;
        logic [SIZE_BITS-1:0]  frame_width;
        logic [SIZE_BITS-1:0]  frame_height;
        logic [COUNT_BITS-1:0] min_count;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // One classified pixel, handed from the front end to the accumulator.
    typedef struct packed {
        logic                  match;
        logic                  end_frame;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
    } t_item;

    typedef struct packed {
        logic                  detected;
        logic [COUNT_BITS-1:0] match_total;
        logic [BOX_BITS-1:0]   box_left;
        logic [BOX_BITS-1:0]   box_right;
        logic [BOX_BITS-1:0]   box_top;
        logic [BOX_BITS-1:0]   box_bottom;
    } t_result;

endpackage

`default_nettype wire

// ----- design/cbcb_front.sv -----
`default_nettype none

module cbcb_front import cbcb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_pixel i_pixel,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_full,
    output logic       o_wr,
    output t_item      o_item
);

    // Last index of a frame dimension; zero acts as one, oversize is clamped.
    function automatic logic [COORD_BITS-1:0] last_index(input logic [SIZE_BITS-1:0] size);
        int eff;
        eff = int'(size);
        if (eff == 0) begin
            eff = 1;
        end else if (eff > (1 << COORD_BITS)) begin
            eff = 1 << COORD_BITS;
        end
        return COORD_BITS'(eff - 1);
    endfunction

    logic [COORD_BITS-1:0] r_column, n_column;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [11:0]           w_sum;
    logic [7:0]            w_luma;
    logic [9:0]            w_luma_x, w_margin_x, w_red_x, w_blue_x;
    logic                  w_match;
    logic                  w_end_row;
    logic                  w_end_frame;

    assign o_wr = i_push && !i_q_full;

    always_comb begin
        w_sum = ({4'b0, i_pixel.red} << 2) + {4'b0, i_pixel.red}
              + ({4'b0, i_pixel.green} << 3) + {4'b0, i_pixel.green}
              + ({4'b0, i_pixel.blue} << 1);
        w_luma     = w_sum[11:4];
        w_luma_x   = {2'b0, w_luma};
        w_margin_x = {2'b0, i_cfg.chroma_margin};
        w_red_x    = {2'b0, i_pixel.red};
        w_blue_x   = {2'b0, i_pixel.blue};
        // U < -m is B + m < luma, and V > m is R > luma + m.
        w_match = (w_luma > i_cfg.dark_level) && (w_luma < i_cfg.bright_level)
               && ((w_blue_x + w_margin_x) < w_luma_x)
               && (w_red_x > (w_luma_x + w_margin_x));
        w_end_row   = r_column >= last_index(i_cfg.frame_width);
        w_end_frame = w_end_row && (r_row >= last_index(i_cfg.frame_height));
    end

    always_comb begin
        o_item.match     = w_match;
        o_item.end_frame = w_end_frame;
        o_item.column    = r_column;
        o_item.row       = r_row;
    end

    always_comb begin
        n_column = r_column;
        n_row    = r_row;
        if (o_wr) begin
            if (w_end_frame) begin
                n_column = '0;
                n_row    = '0;
            end else if (w_end_row) begin
                n_column = '0;
                n_row    = r_row + 1'b1;
            end else begin
                n_column = r_column + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
        end else begin
            r_column <= n_column;
            r_row    <= n_row;
        end
    end

endmodule

`default_nettype wire

// ----- design/cbcb_queue.sv -----
`default_nettype none

module cbcb_queue import cbcb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_wr,
    input  wire t_item i_item,
    input  wire logic  i_rd,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_item
);

    t_item       r_mem [4];
    logic [1:0]  r_wr_ptr, r_rd_ptr;
    logic [2:0]  r_count, n_count;

    assign o_full  = r_count == 3'd4;
    assign o_empty = r_count == 3'd0;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/cbcb_back.sv -----
`default_nettype none

module cbcb_back import cbcb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_empty,
    input  wire t_item i_item,
    input  wire logic [COUNT_BITS-1:0] i_min_count,
    input  wire logic  i_pop,
    output logic       o_rd,
    output logic       o_empty,
    output t_result    o_result
);

    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [COORD_BITS-1:0] r_min_col, n_min_col, r_max_col, n_max_col;
    logic [COORD_BITS-1:0] r_min_row, n_min_row, r_max_row, n_max_row;

    t_result     r_res [2];
    logic        r_res_wr_ptr, r_res_rd_ptr;
    logic [1:0]  r_res_count;
    logic        w_res_full;
    logic        w_res_wr;
    logic        w_res_rd;
    logic        w_any;
    t_result     w_result;

    assign w_res_full = r_res_count == 2'd2;
    assign o_empty    = r_res_count == 2'd0;
    assign w_res_rd   = i_pop && !o_empty;
    assign o_result   = r_res[r_res_rd_ptr];

    // A frame's last pixel needs a free result slot; other pixels never wait.
    assign o_rd     = !i_q_empty && (!i_item.end_frame || !w_res_full);
    assign w_res_wr = o_rd && i_item.end_frame;

    always_comb begin
        n_count   = r_count;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        if (i_item.match) begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
            if (i_item.column < r_min_col) begin
                n_min_col = i_item.column;
            end
            if (i_item.column > r_max_col) begin
                n_max_col = i_item.column;
            end
            if (i_item.row < r_min_row) begin
                n_min_row = i_item.row;
            end
            if (i_item.row > r_max_row) begin
                n_max_row = i_item.row;
            end
        end
    end

    always_comb begin
        w_any = n_count != '0;
        w_result.detected    = n_count > i_min_count;
        w_result.match_total = n_count;
        w_result.box_left    = w_any ? BOX_BITS'(n_min_col) : '0;
        w_result.box_right   = w_any ? BOX_BITS'(n_max_col) : '0;
        w_result.box_top     = w_any ? BOX_BITS'(n_min_row) : '0;
        w_result.box_bottom  = w_any ? BOX_BITS'(n_max_row) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_min_col <= '1;
            r_max_col <= '0;
            r_min_row <= '1;
            r_max_row <= '0;
        end else if (o_rd) begin
            if (i_item.end_frame) begin
                r_count   <= '0;
                r_min_col <= '1;
                r_max_col <= '0;
                r_min_row <= '1;
                r_max_row <= '0;
            end else begin
                r_count   <= n_count;
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_wr) begin
            r_res[r_res_wr_ptr] <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr_ptr <= 1'b0;
            r_res_rd_ptr <= 1'b0;
            r_res_count  <= '0;
        end else begin
            if (w_res_wr) begin
                r_res_wr_ptr <= !r_res_wr_ptr;
            end
            if (w_res_rd) begin
                r_res_rd_ptr <= !r_res_rd_ptr;
            end
            if (w_res_wr && !w_res_rd) begin
                r_res_count <= r_res_count + 1'b1;
            end else if (!w_res_wr && w_res_rd) begin
                r_res_count <= r_res_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/color_blob_count_and_box.sv -----
`default_nettype none
// Channel      Ports                                  Transaction when
// ----------   ------------------------------------   -------------------------
// pixels in    push, full, i_pixel                    push high and full low
// results out  empty, pop, o_result                   pop high and empty low
// config       i_cfg_we, i_cfg_index, i_cfg_data      i_cfg_we high
//
// One pixel transaction is taken every clock cycle while full is low; the
// classifier in the front end is combinational.
// The last pixel of a frame is classified and written into the classification
// queue at the edge that takes it; the accumulator takes it from that queue
// once a result slot is free and writes the frame result into a two-entry
// result queue, from which it can then be popped.
// Reset is synchronous and active low; it restores the register defaults
// and starts a fresh frame at column and row zero.
// When results are not popped, the result queue and then the four-entry
// classification queue fill, and full is raised; nothing is ever dropped.

module color_blob_count_and_box import cbcb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    push,
    input  wire t_pixel  i_pixel,
    output logic         full,
    output logic         empty,
    input  wire logic    pop,
    output t_result      o_result,
    input  wire logic    i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    // Configuration registers. Writes to indexes beyond the list are ignored,
    // and data is truncated to each register's own width.
    t_cfg  r_cfg;

    // Front end to accumulator, through the classification queue.
    logic  w_q_wr;
    logic  w_q_rd;
    logic  w_q_full;
    logic  w_q_empty;
    t_item w_q_in;
    t_item w_q_out;

    assign full = w_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_level    <= LEVEL_BITS'(32);
            r_cfg.bright_level  <= LEVEL_BITS'(64);
            r_cfg.chroma_margin <= LEVEL_BITS'(8);
            r_cfg.frame_width   <= SIZE_BITS'(320);
            r_cfg.frame_height  <= SIZE_BITS'(240);
            r_cfg.min_count     <= COUNT_BITS'(1536);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DARK_LEVEL:    r_cfg.dark_level    <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_BRIGHT_LEVEL:  r_cfg.bright_level  <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_CHROMA_MARGIN: r_cfg.chroma_margin <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_FRAME_WIDTH:   r_cfg.frame_width   <= i_cfg_data[SIZE_BITS-1:0];
                CFG_FRAME_HEIGHT:  r_cfg.frame_height  <= i_cfg_data[SIZE_BITS-1:0];
                CFG_MIN_COUNT:     r_cfg.min_count     <= i_cfg_data[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front end tracks the raster position and classifies each pixel.
    cbcb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pixel  (i_pixel),
        .i_cfg    (r_cfg),
        .i_q_full (w_q_full),
        .o_wr     (w_q_wr),
        .o_item   (w_q_in)
    );

    // A short queue lets the accumulator stall on a full result queue
    // without holding up the pixel stream at once.
    cbcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_item  (w_q_in),
        .i_rd    (w_q_rd),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_item  (w_q_out)
    );

    // The accumulator keeps the count and box and emits one result per frame.
    cbcb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_item      (w_q_out),
        .i_min_count (r_cfg.min_count),
        .i_pop       (pop),
        .o_rd        (w_q_rd),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ----- tb/tb_color_blob_count_and_box.sv -----
module tb_color_blob_count_and_box import cbcb_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes beyond the last real register; writes to them must be ignored.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    // A frame result can be popped once its last pixel has passed through a
    // four-entry classification queue and the accumulator into a two-entry
    // result queue. The settle time comfortably covers a pipeline that is
    // still working on pixels of an unfinished frame.
    localparam int SETTLE_CYCLES = 12;
    // Length of the deliberate output stall that fills the block up.
    localparam int HOLD_CYCLES   = 300;
    // Number of random pixel transactions.
    localparam int RANDOM_PIXELS = 880;
    localparam int CYCLE_LIMIT   = 1000000;

    // Scoreboard: predicts the frame results from the accepted pixels and
    // checks each popped result against the oldest prediction.
    class blob_scoreboard;
        t_cfg                  cfg;
        logic [COORD_BITS-1:0] col_pos, row_pos;
        logic [COORD_BITS-1:0] left_min, right_max, top_min, bottom_max;
        logic [COUNT_BITS-1:0] hit_count;
        t_result               frames_due[$];
        int mismatches, pixels_seen, hits_seen, frames_made, frames_detected;
        int reg_writes;

        function new();
            cfg.dark_level    = 8'd32;
            cfg.bright_level  = 8'd64;
            cfg.chroma_margin = 8'd8;
            cfg.frame_width   = 13'd320;
            cfg.frame_height  = 13'd240;
            cfg.min_count     = 25'd1536;
            clear_frame();
        endfunction

        function void clear_frame();
            col_pos    = '0;
            row_pos    = '0;
            hit_count  = '0;
            left_min   = '1;
            right_max  = '0;
            top_min    = '1;
            bottom_max = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] data);
            reg_writes++;
            case (idx)
                CFG_DARK_LEVEL:    cfg.dark_level    = data[LEVEL_BITS-1:0];
                CFG_BRIGHT_LEVEL:  cfg.bright_level  = data[LEVEL_BITS-1:0];
                CFG_CHROMA_MARGIN: cfg.chroma_margin = data[LEVEL_BITS-1:0];
                CFG_FRAME_WIDTH:   cfg.frame_width   = data[SIZE_BITS-1:0];
                CFG_FRAME_HEIGHT:  cfg.frame_height  = data[SIZE_BITS-1:0];
                CFG_MIN_COUNT:     cfg.min_count     = data[COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Colour test under the present thresholds, in signed arithmetic.
        function bit hits(t_pixel p);
            int luma, u, v, m;
            luma = (5 * int'(p.red) + 9 * int'(p.green) + 2 * int'(p.blue)) >>> 4;
            u    = int'(p.blue) - luma;
            v    = int'(p.red) - luma;
            m    = int'(cfg.chroma_margin);
            return luma > int'(cfg.dark_level) && luma < int'(cfg.bright_level) &&
                   u < -m && v > m;
        endfunction

        // A size of zero acts as one, and anything past the counter span is clipped.
        function logic [COORD_BITS-1:0] last_index(logic [SIZE_BITS-1:0] size);
            if (size == 0)
                return '0;
            if (size > (1 << COORD_BITS))
                return '1;
            return COORD_BITS'(size - 1'b1);
        endfunction

        function void note_pixel(t_pixel p);
            logic [COORD_BITS-1:0] last_col, last_row;
            bit                    row_done;
            t_result               res;
            last_col = last_index(cfg.frame_width);
            last_row = last_index(cfg.frame_height);
            pixels_seen++;
            if (hits(p)) begin
                hits_seen++;
                if (hit_count != COUNT_MAX)
                    hit_count = hit_count + 1'b1;
                if (col_pos < left_min)   left_min   = col_pos;
                if (col_pos > right_max)  right_max  = col_pos;
                if (row_pos < top_min)    top_min    = row_pos;
                if (row_pos > bottom_max) bottom_max = row_pos;
            end
            row_done = col_pos >= last_col;
            if (row_done && row_pos >= last_row) begin
                res.detected    = hit_count > cfg.min_count;
                res.match_total = hit_count;
                if (hit_count != 0) begin
                    res.box_left   = left_min;
                    res.box_right  = right_max;
                    res.box_top    = top_min;
                    res.box_bottom = bottom_max;
                end else begin
                    res.box_left   = '0;
                    res.box_right  = '0;
                    res.box_top    = '0;
                    res.box_bottom = '0;
                end
                frames_due.push_back(res);
                frames_made++;
                if (res.detected)
                    frames_detected++;
                clear_frame();
            end else if (row_done) begin
                col_pos = '0;
                row_pos = row_pos + 1'b1;
            end else begin
                col_pos = col_pos + 1'b1;
            end
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("frame %0d %s: got %0d, expected %0d",
                                 frames_made - frames_due.size(), name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (frames_due.size() == 0) begin
                report("frame result popped with no frame pending");
                return;
            end
            want = frames_due.pop_front();
            check_field("detected",    got.detected,    want.detected);
            check_field("match_total", got.match_total, want.match_total);
            check_field("box_left",    got.box_left,    want.box_left);
            check_field("box_right",   got.box_right,   want.box_right);
            check_field("box_top",     got.box_top,     want.box_top);
            check_field("box_bottom",  got.box_bottom,  want.box_bottom);
        endtask
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      push        = 1'b0;
    t_pixel                    i_pixel     = '0;
    logic                      pop         = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;
    logic                      full;
    logic                      empty;
    t_result                   o_result;

    blob_scoreboard blob_sb = new();

    // Idling switches for either side, and the request for one long output stall.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;
    int cycle_count = 0;

    color_blob_count_and_box u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_pixel     (i_pixel),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Guard against a hung handshake: the run is abandoned well past any
    // plausible length of a correct run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Register value with random junk above the register's width, so that
    // the masking of every narrower write is exercised and every data bit toggles.
    function automatic logic [CFG_DATA_BITS-1:0] cfg_word(int unsigned value, int width);
        int unsigned word;
        word = $urandom;
        if (width < CFG_DATA_BITS)
            word = (word << width) | value;
        else
            word = value;
        return word[CFG_DATA_BITS-1:0];
    endfunction

    // Frame sizes: mostly tiny so that frames end often, sometimes zero,
    // and now and then oversized so that a later shrink ends a frame early.
    function automatic int unsigned pick_size();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 1;
            2:       return $urandom_range(4097, 8191);
            3, 4:    return $urandom_range(9, 40);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic logic [7:0] extreme_byte();
        case ($urandom_range(0, 2))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Pixel content: half of the pixels are aimed at the reddish region where
    // matches live, and a short search makes most of those actually match.
    function automatic t_pixel pick_pixel();
        t_pixel p;
        case ($urandom_range(0, 3))
            0: begin
                p = t_pixel'(24'($urandom));
            end
            1, 2: begin
                p.red   = 8'($urandom_range(48, 255));
                p.green = 8'($urandom_range(0, 80));
                p.blue  = 8'($urandom_range(0, 60));
                for (int k = 0; k < 16 && !blob_sb.hits(p); k++) begin
                    p.red   = 8'($urandom_range(48, 255));
                    p.green = 8'($urandom_range(0, 80));
                    p.blue  = 8'($urandom_range(0, 60));
                end
            end
            default: begin
                p.red   = extreme_byte();
                p.green = extreme_byte();
                p.blue  = extreme_byte();
            end
        endcase
        return p;
    endfunction

    // One pixel transaction, preceded now and then by an idle burst. Push is
    // left high afterwards; the next caller either keeps it high or drops it.
    task automatic send_pixel(input t_pixel p);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        push    <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (full !== 1'b0);
        blob_sb.note_pixel(p);
    endtask

    // A register write takes effect at the edge; the caller lowers the write
    // enable once its last write is done.
    task automatic program_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        blob_sb.write_reg(idx, data);
    endtask

    // Stop offering pixels, wait for every predicted frame result to be
    // popped, then give the pipeline time to finish pixels of an unfinished
    // frame, so that the block is idle before any register changes.
    task automatic settle();
        push <= 1'b0;
        while (blob_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A new random setting: a threshold profile, the frame size and the
    // detection count, each changed only some of the time, so that sizes and
    // thresholds also change in the middle of a frame.
    task automatic shuffle_settings();
        int unsigned dark, bright, margin, min_hits;
        case ($urandom_range(0, 7))
            0: begin
                dark = 0; bright = 255; margin = 0;
            end
            1: begin
                dark = 255; bright = 255; margin = $urandom_range(0, 255);
            end
            2: begin
                dark = $urandom_range(0, 60); bright = 0; margin = $urandom_range(0, 40);
            end
            3: begin
                dark = $urandom_range(0, 60); bright = 255; margin = 255;
            end
            default: begin
                dark   = $urandom_range(0, 60);
                bright = dark + $urandom_range(10, 150);
                margin = $urandom_range(0, 40);
            end
        endcase
        case ($urandom_range(0, 5))
            0:       min_hits = 0;
            1:       min_hits = 32'h1FFFFFF;
            2:       min_hits = $urandom & 32'h1FFFFFF;
            default: min_hits = $urandom_range(0, 12);
        endcase
        if ($urandom_range(0, 1) != 0) begin
            program_reg(CFG_DARK_LEVEL,    cfg_word(dark, LEVEL_BITS));
            program_reg(CFG_BRIGHT_LEVEL,  cfg_word(bright, LEVEL_BITS));
            program_reg(CFG_CHROMA_MARGIN, cfg_word(margin, LEVEL_BITS));
        end
        if ($urandom_range(0, 1) != 0)
            program_reg(CFG_FRAME_WIDTH, cfg_word(pick_size(), SIZE_BITS));
        if ($urandom_range(0, 1) != 0)
            program_reg(CFG_FRAME_HEIGHT, cfg_word(pick_size(), SIZE_BITS));
        if ($urandom_range(0, 2) == 0)
            program_reg(CFG_MIN_COUNT, cfg_word(min_hits, COUNT_BITS));
        if ($urandom_range(0, 7) == 0)
            program_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                        cfg_word($urandom, CFG_DATA_BITS));
        i_cfg_we <= 1'b0;
    endtask

    // Result side: pops with random stalls, checks every popped transaction,
    // and serves the one long stall that the stimulus asks for.
    initial begin : result_drain
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                for (stall = 0; stall < HOLD_CYCLES; stall++) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            blob_sb.check_result(o_result);
        end
    end

    // Stimulus.
    initial begin : stimulus
        int rand_sent, phase_len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: a handful of pixels in a 320 by 240 frame, with
        // pixels on either side of the dark and bright levels and of the
        // chroma margin, plus the corners of the colour cube.
        send_pixel(t_pixel'{8'd100, 8'd20,  8'd0});
        send_pixel(t_pixel'{8'd0,   8'd0,   8'd0});
        send_pixel(t_pixel'{8'd255, 8'd255, 8'd255});
        send_pixel(t_pixel'{8'd80,  8'd12,  8'd4});
        send_pixel(t_pixel'{8'd80,  8'd14,  8'd4});
        send_pixel(t_pixel'{8'd150, 8'd30,  8'd2});
        send_pixel(t_pixel'{8'd150, 8'd29,  8'd2});
        send_pixel(t_pixel'{8'd48,  8'd44,  8'd2});
        send_pixel(t_pixel'{8'd49,  8'd44,  8'd0});
        send_pixel(t_pixel'{8'd255, 8'd0,   8'd0});
        settle();

        // Shrink the frame mid-way: the column is already past the new last
        // index, so the very next pixel closes the row and the frame.
        program_reg(CFG_FRAME_WIDTH,  cfg_word(3, SIZE_BITS));
        program_reg(CFG_FRAME_HEIGHT, cfg_word(1, SIZE_BITS));
        i_cfg_we <= 1'b0;
        send_pixel(t_pixel'{8'd100, 8'd20, 8'd0});
        settle();

        // Widest thresholds, zero frame size acting as one pixel, detection at any
        // count above zero, and writes to the unused indexes that must change nothing.
        program_reg(CFG_DARK_LEVEL,    cfg_word(0, LEVEL_BITS));
        program_reg(CFG_BRIGHT_LEVEL,  cfg_word(255, LEVEL_BITS));
        program_reg(CFG_CHROMA_MARGIN, cfg_word(0, LEVEL_BITS));
        program_reg(CFG_FRAME_WIDTH,   cfg_word(0, SIZE_BITS));
        program_reg(CFG_FRAME_HEIGHT,  cfg_word(0, SIZE_BITS));
        program_reg(CFG_MIN_COUNT,     cfg_word(0, COUNT_BITS));
        program_reg(CFG_SPARE_LO,      cfg_word($urandom, CFG_DATA_BITS));
        program_reg(CFG_SPARE_HI,      cfg_word($urandom, CFG_DATA_BITS));
        i_cfg_we <= 1'b0;
        send_pixel(t_pixel'{8'd100, 8'd20,  8'd0});
        send_pixel(t_pixel'{8'd0,   8'd0,   8'd0});
        send_pixel(t_pixel'{8'd255, 8'd255, 8'd255});
        send_pixel(t_pixel'{8'd255, 8'd0,   8'd0});
        send_pixel(t_pixel'{8'd0,   8'd0,   8'd255});
        settle();

        // Back to the usual thresholds with the largest detection count, in
        // a two by two frame that matches everywhere.
        program_reg(CFG_DARK_LEVEL,    cfg_word(32, LEVEL_BITS));
        program_reg(CFG_BRIGHT_LEVEL,  cfg_word(64, LEVEL_BITS));
        program_reg(CFG_CHROMA_MARGIN, cfg_word(8, LEVEL_BITS));
        program_reg(CFG_FRAME_WIDTH,   cfg_word(2, SIZE_BITS));
        program_reg(CFG_FRAME_HEIGHT,  cfg_word(2, SIZE_BITS));
        program_reg(CFG_MIN_COUNT,     cfg_word(32'h1FFFFFF, COUNT_BITS));
        i_cfg_we <= 1'b0;
        repeat (4) send_pixel(t_pixel'{8'd100, 8'd20, 8'd0});
        settle();

        // An oversized width register is clipped to the counter span, so a
        // long row runs on; shrinking the width then closes the row and the
        // frame on the next pixel. Matches at both ends set the box edges.
        program_reg(CFG_FRAME_WIDTH,  cfg_word(8191, SIZE_BITS));
        program_reg(CFG_FRAME_HEIGHT, cfg_word(1, SIZE_BITS));
        i_cfg_we <= 1'b0;
        for (int i = 0; i < 100; i++)
            send_pixel((i == 0 || i == 99) ? t_pixel'{8'd100, 8'd20, 8'd0} : pick_pixel());
        settle();
        program_reg(CFG_FRAME_WIDTH, cfg_word(3, SIZE_BITS));
        i_cfg_we <= 1'b0;
        send_pixel(t_pixel'{8'd100, 8'd20, 8'd0});
        settle();

        // The same for the height: one pixel per row in a tall frame, which
        // a later shrink of the height closes on the next pixel.
        program_reg(CFG_FRAME_WIDTH,  cfg_word(1, SIZE_BITS));
        program_reg(CFG_FRAME_HEIGHT, cfg_word(8191, SIZE_BITS));
        i_cfg_we <= 1'b0;
        for (int i = 0; i < 100; i++)
            send_pixel((i == 0 || i == 99) ? t_pixel'{8'd100, 8'd20, 8'd0} : pick_pixel());
        settle();
        program_reg(CFG_FRAME_HEIGHT, cfg_word(1, SIZE_BITS));
        i_cfg_we <= 1'b0;
        send_pixel(t_pixel'{8'd100, 8'd20, 8'd0});
        settle();

        // Back-pressure: every pixel is a frame while the result side holds
        // off for a long stretch, so both internal queues fill and full rises.
        program_reg(CFG_FRAME_WIDTH,  cfg_word(1, SIZE_BITS));
        program_reg(CFG_FRAME_HEIGHT, cfg_word(1, SIZE_BITS));
        i_cfg_we <= 1'b0;
        hold_req = 1'b1;
        repeat (40) send_pixel(pick_pixel());
        settle();

        // Random phases: new settings, then a run of pixels that often stops
        // in the middle of a frame. The last stretch runs without idling.
        rand_sent = 0;
        while (rand_sent < RANDOM_PIXELS) begin
            if (rand_sent >= RANDOM_PIXELS - 150) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            shuffle_settings();
            phase_len = $urandom_range(1, 60);
            repeat (phase_len) send_pixel(pick_pixel());
            rand_sent += phase_len;
            settle();
        end

        $display("Run covered %0d pixels (%0d matching) in %0d frame results, %0d detected.",
                 blob_sb.pixels_seen, blob_sb.hits_seen, blob_sb.frames_made,
                 blob_sb.frames_detected);
        $display("%0d register writes, mid-frame size changes and one long output stall.",
                 blob_sb.reg_writes);
        if (blob_sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
